>>> hw/rtl/fbik_pkg.sv
package fbik_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int LEN_W     = 17;
    localparam int ANG_W     = 16;
    localparam int OUT_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_REAR_LINK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_PASSIVE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_PASSIVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_LINK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPAN     = 3'd4;

    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [32:0] KINV_Q30    = 33'sd652032874;

    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = SQRT_W / 2;

    // 3845054676 split in 16-bit halves
    localparam logic [15:0] DEG_K_HI = 16'd58670;
    localparam logic [15:0] DEG_K_LO = 16'd57556;

    localparam logic signed [21:0] FRONT_OFS = 22'sd11520;
    localparam logic signed [21:0] REAR_OFS  = 22'sd34560;

    localparam logic signed [31:0] ATAN_SMALL [10] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
        32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287
    };

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] e;
        logic signed [31:0] f;
    } coef_t;

    function automatic logic signed [31:0] atan_term(input int unsigned i);
        logic signed [31:0] t;
        if (i < 10)
            t = ATAN_SMALL[i[3:0]];
        else if (i > 28)
            t = '0;
        else
            t = 32'sd1 <<< (28 - i);
        return t;
    endfunction

endpackage

>>> hw/rtl/fbik_if.sv
interface fbik_target_if;
    logic                                valid;
    logic                                ready;
    logic        [fbik_pkg::LEN_W-1:0]   leg_length;
    logic signed [fbik_pkg::ANG_W-1:0]   leg_angle;

    modport source (output valid, leg_length, leg_angle, input ready);
    modport sink (input valid, leg_length, leg_angle, output ready);
endinterface

interface fbik_servo_if;
    logic                                valid;
    logic                                ready;
    logic signed [fbik_pkg::OUT_W-1:0]   front_angle;
    logic signed [fbik_pkg::OUT_W-1:0]   rear_angle;
    logic                                unreachable;

    modport source (output valid, front_angle, rear_angle, unreachable, input ready);
    modport sink (input valid, front_angle, rear_angle, unreachable, output ready);
endinterface

>>> hw/rtl/fbik_isqrt.sv
module fbik_isqrt (
    input  logic                                clk,
    input  logic                                en,
    input  logic [fbik_pkg::SQRT_W-1:0]         radicand,
    output logic [fbik_pkg::SQRT_STEPS-1:0]     root
);
    localparam int W     = fbik_pkg::SQRT_W;
    localparam int STEPS = fbik_pkg::SQRT_STEPS;
    localparam int REM_W = STEPS + 4;

    logic [W-1:0]       v_reg   [0:STEPS-1];
    logic [REM_W-1:0]   rem_reg [0:STEPS-1];
    logic [STEPS-1:0]   q_reg   [0:STEPS-1];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [W-1:0]       v_in;
        logic [REM_W-1:0]   rem_in;
        logic [STEPS-1:0]   q_in;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;

        if (j == 0) begin : g_first
            assign v_in   = radicand;
            assign rem_in = '0;
            assign q_in   = '0;
        end
        else begin : g_rest
            assign v_in   = v_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], v_in[W-1:W-2]};
        assign trial  = REM_W'({q_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j] <= v_in << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg[j] <= rem_sh - trial;
                    q_reg[j]   <= {q_in[STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= rem_sh;
                    q_reg[j]   <= {q_in[STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign root = q_reg[STEPS-1];

endmodule

>>> hw/rtl/fbik_atan2.sv
module fbik_atan2 #(
    parameter int STEPS = fbik_pkg::CORDIC_STEPS
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  y_in,
    input  logic signed [31:0]  x_in,
    output logic signed [31:0]  z_out
);
    localparam int VW = 36;
    localparam int MW = 33;

    logic signed [VW-1:0] n1_x_reg, n1_y_reg, n2_x_reg, n2_y_reg;
    logic        [MW-1:0] n1_m_reg, n2_m_reg;
    logic                 n1_zero_reg, n2_zero_reg;

    logic signed [VW-1:0] c_x_reg    [0:STEPS];
    logic signed [VW-1:0] c_y_reg    [0:STEPS];
    logic signed [31:0]   c_z_reg    [0:STEPS];
    logic                 c_zero_reg [0:STEPS];

    logic signed [VW-1:0] n1_x_next, n1_y_next, n2_x_next, n2_y_next;
    logic signed [VW-1:0] n3_x_next, n3_y_next;
    logic        [MW-1:0] n1_m_next, n2_m_next, n3_m;
    logic signed [31:0]   n3_z_next;

    // normalize: coarse shifts
    always_comb
    begin
        logic [MW-1:0] ax, ay;
        ax = x_in[31] ? MW'(-x_in) : MW'(x_in);
        ay = y_in[31] ? MW'(-y_in) : MW'(y_in);
        n1_m_next = (ax > ay) ? ax : ay;
        n1_x_next = VW'(x_in);
        n1_y_next = VW'(y_in);
        if (n1_m_next < (MW'(1) << 13))
        begin
            n1_x_next = n1_x_next <<< 16;
            n1_y_next = n1_y_next <<< 16;
            n1_m_next = n1_m_next << 16;
        end
        if (n1_m_next < (MW'(1) << 21))
        begin
            n1_x_next = n1_x_next <<< 8;
            n1_y_next = n1_y_next <<< 8;
            n1_m_next = n1_m_next << 8;
        end
    end

    always_comb
    begin
        n2_x_next = n1_x_reg;
        n2_y_next = n1_y_reg;
        n2_m_next = n1_m_reg;
        if (n2_m_next < (MW'(1) << 25))
        begin
            n2_x_next = n2_x_next <<< 4;
            n2_y_next = n2_y_next <<< 4;
            n2_m_next = n2_m_next << 4;
        end
        if (n2_m_next < (MW'(1) << 27))
        begin
            n2_x_next = n2_x_next <<< 2;
            n2_y_next = n2_y_next <<< 2;
            n2_m_next = n2_m_next << 2;
        end
    end

    // fine shifts, then fold a left half-plane vector by a quarter turn
    always_comb
    begin
        logic signed [VW-1:0] xs, ys;
        xs   = n2_x_reg;
        ys   = n2_y_reg;
        n3_m = n2_m_reg;
        if (n3_m < (MW'(1) << 28))
        begin
            xs   = xs <<< 1;
            ys   = ys <<< 1;
            n3_m = n3_m << 1;
        end
        if (n3_m < (MW'(1) << 29))
        begin
            xs   = xs <<< 1;
            ys   = ys <<< 1;
            n3_m = n3_m << 1;
        end
        n3_x_next = xs;
        n3_y_next = ys;
        n3_z_next = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                n3_x_next = ys;
                n3_y_next = -xs;
                n3_z_next = fbik_pkg::HALF_PI_Q28;
            end
            else
            begin
                n3_x_next = -ys;
                n3_y_next = xs;
                n3_z_next = -fbik_pkg::HALF_PI_Q28;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_x_reg      <= n1_x_next;
            n1_y_reg      <= n1_y_next;
            n1_m_reg      <= n1_m_next;
            n1_zero_reg   <= (x_in == '0) && (y_in == '0);
            n2_x_reg      <= n2_x_next;
            n2_y_reg      <= n2_y_next;
            n2_m_reg      <= n2_m_next;
            n2_zero_reg   <= n1_zero_reg;
            c_x_reg[0]    <= n3_x_next;
            c_y_reg[0]    <= n3_y_next;
            c_z_reg[0]    <= n3_z_next;
            c_zero_reg[0] <= n2_zero_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_vec
        localparam logic signed [31:0] ATAN_I = fbik_pkg::atan_term(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                c_zero_reg[i+1] <= c_zero_reg[i];
                if (c_y_reg[i] >= 0)
                begin
                    c_x_reg[i+1] <= c_x_reg[i] + (c_y_reg[i] >>> i);
                    c_y_reg[i+1] <= c_y_reg[i] - (c_x_reg[i] >>> i);
                    c_z_reg[i+1] <= c_z_reg[i] + ATAN_I;
                end
                else
                begin
                    c_x_reg[i+1] <= c_x_reg[i] - (c_y_reg[i] >>> i);
                    c_y_reg[i+1] <= c_y_reg[i] + (c_x_reg[i] >>> i);
                    c_z_reg[i+1] <= c_z_reg[i] - ATAN_I;
                end
            end
        end
    end

    assign z_out = c_zero_reg[STEPS] ? '0 : c_z_reg[STEPS];

endmodule

>>> hw/rtl/five_bar_leg_inverse_kinematics_unit.sv
// Five-bar leg inverse kinematics. Each target word (leg_length, leg_angle) gives one servo
// word (front_angle, rear_angle, unreachable). The pipeline takes one word per clock while the
// output is not stalled; each word passes through the sine/cosine CORDIC, the 32-stage square
// root and the atan2 CORDIC in series.
// A stalled output freezes the whole pipeline. Link lengths are to be written on the cfg port
// only while no word is in flight; the block itself does not enforce this.
module five_bar_leg_inverse_kinematics_unit #(
    parameter int CORDIC_STEPS = fbik_pkg::CORDIC_STEPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbik_pkg::LEN_W-1:0]          cfg_data,
    fbik_target_if.sink                         target,
    fbik_servo_if.source                        servo
);
    localparam int N      = CORDIC_STEPS;
    localparam int SQ_LAT = fbik_pkg::SQRT_STEPS;
    localparam int AT_LAT = 3 + N;
    localparam int LAT    = N + 1 + 6 + SQ_LAT + AT_LAT + 4;
    localparam int SB_LEN = 3 + SQ_LAT;
    localparam int UD     = SQ_LAT + AT_LAT + 4;
    localparam int LW     = fbik_pkg::LEN_W;
    localparam int PW     = 48;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LW-1:0]  len_reg [0:4];

    assign en           = !vld_reg[LAT-1] || servo.ready;
    assign target.ready = en;
    assign servo.valid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int k = 0; k < 5; k++)
                len_reg[k] <= '0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], target.valid};
            if (cfg_we)
            begin
                case (cfg_index)
                    fbik_pkg::REG_REAR_LINK:     len_reg[0] <= cfg_data;
                    fbik_pkg::REG_REAR_PASSIVE:  len_reg[1] <= cfg_data;
                    fbik_pkg::REG_FRONT_PASSIVE: len_reg[2] <= cfg_data;
                    fbik_pkg::REG_FRONT_LINK:    len_reg[3] <= cfg_data;
                    fbik_pkg::REG_BASE_SPAN:     len_reg[4] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // sine/cosine CORDIC
    logic signed [32:0] sc_x_reg   [0:N];
    logic signed [32:0] sc_y_reg   [0:N];
    logic signed [31:0] sc_z_reg   [0:N];
    logic [LW-1:0]      sc_r_reg   [0:N];
    logic               sc_neg_reg [0:N];

    always_ff @(posedge clk)
    begin
        logic signed [31:0] z0;
        z0 = {target.leg_angle[15], target.leg_angle, 15'b0};
        if (en)
        begin
            sc_x_reg[0] <= fbik_pkg::KINV_Q30;
            sc_y_reg[0] <= '0;
            sc_r_reg[0] <= target.leg_length;
            if (z0 > fbik_pkg::HALF_PI_Q28)
            begin
                sc_z_reg[0]   <= z0 - fbik_pkg::PI_Q28;
                sc_neg_reg[0] <= 1'b1;
            end
            else if (z0 < -fbik_pkg::HALF_PI_Q28)
            begin
                sc_z_reg[0]   <= z0 + fbik_pkg::PI_Q28;
                sc_neg_reg[0] <= 1'b1;
            end
            else
            begin
                sc_z_reg[0]   <= z0;
                sc_neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [31:0] ATAN_I = fbik_pkg::atan_term(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sc_r_reg[i+1]   <= sc_r_reg[i];
                sc_neg_reg[i+1] <= sc_neg_reg[i];
                if (sc_z_reg[i] >= 0)
                begin
                    sc_x_reg[i+1] <= sc_x_reg[i] - (sc_y_reg[i] >>> i);
                    sc_y_reg[i+1] <= sc_y_reg[i] + (sc_x_reg[i] >>> i);
                    sc_z_reg[i+1] <= sc_z_reg[i] - ATAN_I;
                end
                else
                begin
                    sc_x_reg[i+1] <= sc_x_reg[i] + (sc_y_reg[i] >>> i);
                    sc_y_reg[i+1] <= sc_y_reg[i] - (sc_x_reg[i] >>> i);
                    sc_z_reg[i+1] <= sc_z_reg[i] + ATAN_I;
                end
            end
        end
    end

    // geometry
    logic signed [50:0] m1_pc_reg, m1_ps_reg;
    logic signed [20:0] m2_x_reg, m2_y_reg;
    logic signed [21:0] m2_dx_reg;
    logic signed [PW-1:0] m3_xa_reg, m3_ya_reg, m3_da_reg, m3_ye_reg;
    logic signed [PW-1:0] m3_xx_reg, m3_yy_reg, m3_dd_reg;
    logic signed [PW-1:0] m3_l1_reg, m3_l2_reg, m3_l3_reg, m3_l4_reg;
    fbik_pkg::coef_t    sb_reg [0:SB_LEN-1];
    fbik_pkg::coef_t    coef_next;
    logic signed [63:0] m5_sq_reg [0:5];
    logic signed [63:0] m6_d1_reg, m6_d2_reg;
    logic               unr_reg [0:UD-1];

    logic signed [32:0] cs, sn;
    logic signed [17:0] r_s;
    logic signed [50:0] pc_sh, ps_sh;
    logic signed [20:0] x_next, y_next;
    logic signed [18:0] a1, a2, a3, a4;
    logic signed [63:0] d1_next, d2_next;

    assign cs  = sc_neg_reg[N] ? -sc_x_reg[N] : sc_x_reg[N];
    assign sn  = sc_neg_reg[N] ? -sc_y_reg[N] : sc_y_reg[N];
    assign r_s = $signed({1'b0, sc_r_reg[N]});

    assign pc_sh  = (m1_pc_reg + (51'sd1 <<< 28)) >>> 29;
    assign ps_sh  = (m1_ps_reg + (51'sd1 <<< 28)) >>> 29;
    assign x_next = 21'(pc_sh) + 21'($signed({1'b0, len_reg[4]}));
    assign y_next = 21'(ps_sh);

    assign a1 = $signed({1'b0, len_reg[0], 1'b0});
    assign a2 = $signed({1'b0, len_reg[1], 1'b0});
    assign a3 = $signed({1'b0, len_reg[2], 1'b0});
    assign a4 = $signed({1'b0, len_reg[3], 1'b0});

    always_comb
    begin
        coef_next.a = 32'((m3_xa_reg <<< 1) >>> 10);
        coef_next.b = 32'((m3_ya_reg <<< 1) >>> 10);
        coef_next.c = 32'((m3_xx_reg + m3_yy_reg + m3_l1_reg - m3_l2_reg) >>> 10);
        coef_next.d = 32'((m3_da_reg <<< 1) >>> 10);
        coef_next.e = 32'((m3_ye_reg <<< 1) >>> 10);
        coef_next.f = 32'((m3_dd_reg + m3_yy_reg + m3_l4_reg - m3_l3_reg) >>> 10);
    end

    assign d1_next = m5_sq_reg[0] + m5_sq_reg[1] - m5_sq_reg[2];
    assign d2_next = m5_sq_reg[3] + m5_sq_reg[4] - m5_sq_reg[5];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_pc_reg <= 51'(r_s) * 51'(cs);
            m1_ps_reg <= 51'(r_s) * 51'(sn);

            m2_x_reg  <= x_next;
            m2_y_reg  <= y_next;
            m2_dx_reg <= 22'(x_next) - 22'($signed({1'b0, len_reg[4], 1'b0}));

            m3_xa_reg <= PW'(m2_x_reg) * PW'(a1);
            m3_ya_reg <= PW'(m2_y_reg) * PW'(a1);
            m3_da_reg <= PW'(m2_dx_reg) * PW'(a4);
            m3_ye_reg <= PW'(m2_y_reg) * PW'(a4);
            m3_xx_reg <= PW'(m2_x_reg) * PW'(m2_x_reg);
            m3_yy_reg <= PW'(m2_y_reg) * PW'(m2_y_reg);
            m3_dd_reg <= PW'(m2_dx_reg) * PW'(m2_dx_reg);
            m3_l1_reg <= PW'(a1) * PW'(a1);
            m3_l2_reg <= PW'(a2) * PW'(a2);
            m3_l3_reg <= PW'(a3) * PW'(a3);
            m3_l4_reg <= PW'(a4) * PW'(a4);

            sb_reg[0] <= coef_next;
            for (int k = 1; k < SB_LEN; k++)
                sb_reg[k] <= sb_reg[k-1];

            m5_sq_reg[0] <= 64'(sb_reg[0].a) * 64'(sb_reg[0].a);
            m5_sq_reg[1] <= 64'(sb_reg[0].b) * 64'(sb_reg[0].b);
            m5_sq_reg[2] <= 64'(sb_reg[0].c) * 64'(sb_reg[0].c);
            m5_sq_reg[3] <= 64'(sb_reg[0].d) * 64'(sb_reg[0].d);
            m5_sq_reg[4] <= 64'(sb_reg[0].e) * 64'(sb_reg[0].e);
            m5_sq_reg[5] <= 64'(sb_reg[0].f) * 64'(sb_reg[0].f);

            m6_d1_reg  <= d1_next;
            m6_d2_reg  <= d2_next;
            unr_reg[0] <= d1_next[63] || d2_next[63];
            for (int k = 1; k < UD; k++)
                unr_reg[k] <= unr_reg[k-1];
        end
    end

    // square roots of both discriminants
    logic [SQ_LAT-1:0] s1, s2;

    fbik_isqrt u_sqrt_rear (
        .clk      (clk),
        .en       (en),
        .radicand (m6_d1_reg),
        .root     (s1)
    );

    fbik_isqrt u_sqrt_front (
        .clk      (clk),
        .en       (en),
        .radicand (m6_d2_reg),
        .root     (s2)
    );

    // four atan2 terms
    fbik_pkg::coef_t    cq;
    logic signed [31:0] z1, z2, z3, z4;

    assign cq = sb_reg[SB_LEN-1];

    fbik_atan2 #(.STEPS(N)) u_atan_ba (
        .clk (clk), .en (en), .y_in (cq.b), .x_in (cq.a), .z_out (z1)
    );

    fbik_atan2 #(.STEPS(N)) u_atan_sc (
        .clk (clk), .en (en), .y_in ($signed(s1)), .x_in (cq.c), .z_out (z2)
    );

    fbik_atan2 #(.STEPS(N)) u_atan_ed (
        .clk (clk), .en (en), .y_in (cq.e), .x_in (cq.d), .z_out (z3)
    );

    fbik_atan2 #(.STEPS(N)) u_atan_sf (
        .clk (clk), .en (en), .y_in ($signed(s2)), .x_in (cq.f), .z_out (z4)
    );

    // radians to degrees*128, servo offsets
    logic signed [32:0] phi1_reg, phi4_reg;
    logic signed [49:0] p1_hi_reg, p1_lo_reg, p4_hi_reg, p4_lo_reg;
    logic signed [20:0] deg1_reg, deg4_reg;
    logic signed [fbik_pkg::OUT_W-1:0] front_reg, rear_reg;
    logic               unreach_reg;
    logic signed [67:0] sum1, sum4;
    logic signed [21:0] front_next, rear_next;

    assign sum1 = (68'(p1_hi_reg) <<< 16) + 68'(p1_lo_reg) + (68'sd1 <<< 46);
    assign sum4 = (68'(p4_hi_reg) <<< 16) + 68'(p4_lo_reg) + (68'sd1 <<< 46);
    assign front_next = 22'(deg4_reg) + fbik_pkg::FRONT_OFS;
    assign rear_next  = fbik_pkg::REAR_OFS - 22'(deg1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi1_reg <= 33'(z1) + 33'(z2);
            phi4_reg <= 33'(z3) - 33'(z4);

            p1_hi_reg <= 50'(phi1_reg) * 50'($signed({1'b0, fbik_pkg::DEG_K_HI}));
            p1_lo_reg <= 50'(phi1_reg) * 50'($signed({1'b0, fbik_pkg::DEG_K_LO}));
            p4_hi_reg <= 50'(phi4_reg) * 50'($signed({1'b0, fbik_pkg::DEG_K_HI}));
            p4_lo_reg <= 50'(phi4_reg) * 50'($signed({1'b0, fbik_pkg::DEG_K_LO}));

            deg1_reg <= 21'(sum1 >>> 47);
            deg4_reg <= 21'(sum4 >>> 47);

            unreach_reg <= unr_reg[UD-1];
            if (unr_reg[UD-1])
            begin
                front_reg <= '0;
                rear_reg  <= '0;
            end
            else
            begin
                front_reg <= front_next[fbik_pkg::OUT_W-1:0];
                rear_reg  <= rear_next[fbik_pkg::OUT_W-1:0];
            end
        end
    end

    assign servo.front_angle = front_reg;
    assign servo.rear_angle  = rear_reg;
    assign servo.unreachable = unreach_reg;

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        servo.valid && servo.unreachable |-> servo.front_angle == '0 && servo.rear_angle == '0)
        else $error("unreachable word with nonzero angles");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        target.valid && target.ready |=> vld_reg[0])
        else $error("accepted word not in pipeline");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-2] |=> servo.valid)
        else $error("word lost at output stage");

endmodule

>>> test/tb_five_bar_leg_inverse_kinematics_unit.sv
`timescale 1ns / 1ps

module tb_five_bar_leg_inverse_kinematics_unit;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 2 * fbik_pkg::CORDIC_STEPS + 60;

    typedef struct {
        logic signed [fbik_pkg::OUT_W-1:0] front;
        logic signed [fbik_pkg::OUT_W-1:0] rear;
        logic                              unreach;
    } servo_word_t;

    class servo_scoreboard;
        longint      link_len [5];
        servo_word_t pending [$];

        function void set_len(int idx, longint v);
            if (idx < 5)
                link_len[idx] = v & 64'h1FFFF;
        endfunction

        function longint arc_step(int i);
            longint tab [10];
            tab = '{210828714, 124459457, 65760959, 33381290, 16755422,
                    8385879, 4193963, 2097109, 1048571, 524287};
            if (i < 10)
                return tab[i];
            if (i > 28)
                return 0;
            return longint'(1) <<< (28 - i);
        endfunction

        function void rotate(longint z, output longint cs, output longint sn);
            longint x, y, dx, dy;
            bit     flip;
            x = fbik_pkg::KINV_Q30;
            y = 0;
            flip = 0;
            if (z > fbik_pkg::HALF_PI_Q28)
            begin
                z -= fbik_pkg::PI_Q28;
                flip = 1;
            end
            else if (z < -fbik_pkg::HALF_PI_Q28)
            begin
                z += fbik_pkg::PI_Q28;
                flip = 1;
            end
            for (int i = 0; i < fbik_pkg::CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= arc_step(i);
                end
                else
                begin
                    x += dx; y -= dy; z += arc_step(i);
                end
            end
            cs = flip ? -x : x;
            sn = flip ? -y : y;
        endfunction

        function longint bearing(longint y, longint x);
            longint z, m, ax, ay, t, dx, dy;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            m = ax > ay ? ax : ay;
            while (m < (longint'(1) <<< 29))
            begin
                x *= 2; y *= 2; m *= 2;
            end
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = fbik_pkg::HALF_PI_Q28;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -fbik_pkg::HALF_PI_Q28;
                end
            end
            for (int i = 0; i < fbik_pkg::CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += arc_step(i);
                end
                else
                begin
                    x -= dx; y += dy; z -= arc_step(i);
                end
            end
            return z;
        endfunction

        function longint root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = longint'(1) << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function longint to_deg(longint p);
            return (p * 64'sd3845054676 + (longint'(1) <<< 46)) >>> 47;
        endfunction

        function void note(logic [fbik_pkg::LEN_W-1:0] len,
                           logic signed [fbik_pkg::ANG_W-1:0] ang);
            longint      r, th, cs, sn, x, y, dx, a1, a2, a3, a4, b5;
            longint      a, b, c, d, e, f, d1, d2, phi1, phi4;
            servo_word_t w;
            r = len;
            th = ang;
            rotate(th * 32768, cs, sn);
            a1 = 2 * link_len[0]; a2 = 2 * link_len[1];
            a3 = 2 * link_len[2]; a4 = 2 * link_len[3];
            b5 = 2 * link_len[4];
            x = link_len[4] + ((r * cs + (longint'(1) <<< 28)) >>> 29);
            y = (r * sn + (longint'(1) <<< 28)) >>> 29;
            dx = x - b5;
            a = (2 * x * a1) >>> 10;
            b = (2 * y * a1) >>> 10;
            c = (x * x + y * y + a1 * a1 - a2 * a2) >>> 10;
            d = (2 * a4 * dx) >>> 10;
            e = (2 * a4 * y) >>> 10;
            f = (dx * dx + y * y + a4 * a4 - a3 * a3) >>> 10;
            d1 = a * a + b * b - c * c;
            d2 = d * d + e * e - f * f;
            if (d1 < 0 || d2 < 0)
            begin
                w.front = '0;
                w.rear = '0;
                w.unreach = 1'b1;
            end
            else
            begin
                phi1 = bearing(b, a) + bearing(root(d1), c);
                phi4 = bearing(e, d) - bearing(root(d2), f);
                w.front = fbik_pkg::OUT_W'(to_deg(phi4) + 11520);
                w.rear = fbik_pkg::OUT_W'(34560 - to_deg(phi1));
                w.unreach = 1'b0;
            end
            pending.push_back(w);
        endfunction

        function bit check(servo_word_t got, output string msg);
            servo_word_t want;
            want = pending.pop_front();
            msg = $sformatf("front %0d/%0d rear %0d/%0d unreachable %0b/%0b (got/exp)",
                            got.front, want.front, got.rear, want.rear,
                            got.unreach, want.unreach);
            return got.front === want.front && got.rear === want.rear &&
                   got.unreach === want.unreach;
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fbik_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fbik_pkg::LEN_W-1:0]     cfg_data;

    fbik_target_if target ();
    fbik_servo_if  servo ();

    five_bar_leg_inverse_kinematics_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .target    (target.sink),
        .servo     (servo.source)
    );

    servo_scoreboard sb;
    int              errors;
    int              cycles;
    bit              quiet;
    bit              long_hold;
    longint          l1, l2;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (target.valid && target.ready)
            sb.note(target.leg_length, target.leg_angle);
    end

    always @(posedge clk)
    begin
        servo_word_t got;
        string       msg;
        if (servo.valid && servo.ready)
        begin
            got.front = servo.front_angle;
            got.rear = servo.rear_angle;
            got.unreach = servo.unreachable;
            if (sb.pending.size() == 0)
                report("servo word with nothing expected");
            else if (!sb.check(got, msg))
                report(msg);
        end
    end

    // receiver
    initial
    begin
        servo.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                servo.ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 0;
                servo.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(7) == 0)
            begin
                servo.ready <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge clk);
                servo.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [fbik_pkg::LEN_W-1:0] len,
                             logic signed [fbik_pkg::ANG_W-1:0] ang);
        target.valid <= 1'b1;
        target.leg_length <= len;
        target.leg_angle <= ang;
        @(posedge clk);
        while (!target.ready)
            @(posedge clk);
        if (!quiet && $urandom_range(5) == 0)
        begin
            target.valid <= 1'b0;
            target.leg_length <= fbik_pkg::LEN_W'($urandom);
            target.leg_angle <= fbik_pkg::ANG_W'($urandom);
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        target.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [fbik_pkg::CFG_IDX_W-1:0] idx, longint v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= fbik_pkg::LEN_W'(v);
        sb.set_len(idx, v);
        @(posedge clk);
    endtask

    task automatic set_links(longint r1, longint r2, longint f3, longint f4, longint s5);
        write_reg(fbik_pkg::REG_REAR_LINK, r1);
        write_reg(fbik_pkg::REG_REAR_PASSIVE, r2);
        write_reg(fbik_pkg::REG_FRONT_PASSIVE, f3);
        write_reg(fbik_pkg::REG_FRONT_LINK, f4);
        write_reg(fbik_pkg::REG_BASE_SPAN, s5);
        cfg_we <= 1'b0;
        @(posedge clk);
        l1 = r1;
        l2 = r2;
    endtask

    task automatic random_word();
        longint reach;
        reach = l1 + l2;
        if (reach > 131071)
            reach = 131071;
        if ($urandom_range(3) != 0)
            send_word(fbik_pkg::LEN_W'($urandom_range(reach)),
                      fbik_pkg::ANG_W'($signed($urandom_range(17700, 8000)) *
                                       ($urandom_range(3) == 0 ? -1 : 1)));
        else
            send_word(fbik_pkg::LEN_W'($urandom), fbik_pkg::ANG_W'($urandom));
    endtask

    initial
    begin
        sb = new();
        errors = 0;
        cycles = 0;
        quiet = 0;
        long_hold = 0;
        l1 = 0;
        l2 = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        target.valid = 1'b0;
        target.leg_length = '0;
        target.leg_angle = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate: all lengths zero after reset
        send_word(17'd0, 16'sd0);
        send_word(17'd131071, 16'sd12868);
        send_word(17'd5000, -16'sd32768);
        drain();

        // zero rear link: atan2 of a zero vector
        set_links(0, 10000, 13107, 6554, 4000);
        send_word(17'd8000, 16'sd12868);
        send_word(17'd0, 16'sd0);
        drain();

        set_links(6554, 13107, 13107, 6554, 4000);
        // unused indexes are ignored
        write_reg(3'd5, 17'h1FFFF);
        write_reg(3'd6, 17'h1FFFF);
        write_reg(3'd7, 17'h15555);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_word(17'd0, 16'sd0);
        send_word(17'd131071, 16'sd0);
        send_word(17'd15000, 16'sd12868);
        send_word(17'd15000, -16'sd12868);
        send_word(17'd15000, 16'sd12869);
        send_word(17'd15000, -16'sd12869);
        send_word(17'd12000, 16'sd25736);
        send_word(17'd12000, -16'sd25736);
        send_word(17'd12000, 16'sd32767);
        send_word(17'd12000, -16'sd32768);
        send_word(17'd16000, 16'sd10000);
        send_word(17'd10000, 16'sd16000);
        send_word(17'd100000, 16'sd12868);
        send_word(17'h15555, 16'sh5555);
        send_word(17'h0AAAA, -16'sh5556);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_links(6554, 13107, 13107, 6554, 4000);
                1: set_links(131071, 131071, 131071, 131071, 131071);
                2: set_links($urandom_range(20000, 2000), $urandom_range(40000, 5000),
                             $urandom_range(40000, 5000), $urandom_range(20000, 2000),
                             $urandom_range(20000));
                3: set_links(131071, 131071, 131071, 131071, 0);
                4: set_links($urandom, $urandom, $urandom, $urandom, $urandom);
                default: set_links(10000, 20000, 20000, 10000, 0);
            endcase
            if (ph == 5)
                quiet = 1;
            for (int n = 0; n < 290; n++)
            begin
                if (ph == 1 && n == 40)
                    long_hold = 1;
                if (ph == 2 && n == 100)
                    drain();
                random_word();
            end
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> five_bar_leg_inverse_kinematics_unit.f
hw/rtl/fbik_pkg.sv
hw/rtl/fbik_if.sv
hw/rtl/fbik_isqrt.sv
hw/rtl/fbik_atan2.sv
hw/rtl/five_bar_leg_inverse_kinematics_unit.sv
test/tb_five_bar_leg_inverse_kinematics_unit.sv
